// ===== hw/rtl/bpbp_pkg.sv =====
// Shared field codes and field width masks for the primary block parser.
package bpbp_pkg;

   localparam int unsigned FieldIdWidth = 5;
   localparam int unsigned ValueWidth   = 64;
   localparam int unsigned DictWidth    = 32;

   typedef logic [FieldIdWidth-1:0] field_id_type;
   typedef logic [ValueWidth-1:0]   value_type;
   typedef logic [DictWidth-1:0]    dict_count_type;

   localparam field_id_type FID_VERSION      = 5'd0;
   localparam field_id_type FID_FLAGS        = 5'd1;
   localparam field_id_type FID_OFFSET_FIRST = 5'd3;
   localparam field_id_type FID_OFFSET_LAST  = 5'd18;
   localparam field_id_type FID_TIMESTAMP    = 5'd19;
   localparam field_id_type FID_LIFETIME     = 5'd21;
   localparam field_id_type FID_DICT_LEN     = 5'd22;
   localparam field_id_type FID_DICT_BYTE    = 5'd23;
   localparam field_id_type FID_FRAG         = 5'd24;
   localparam field_id_type FID_ADU          = 5'd25;

   // Each decoded field is cut down to the width it is stored at.
   function automatic value_type width_mask(input field_id_type id);
      value_type mask;
      case (id) inside
         FID_FLAGS:                           mask = 64'h0000_0000_0000_00FF;
         [FID_OFFSET_FIRST:FID_OFFSET_LAST]:  mask = 64'h0000_0000_0000_FFFF;
         FID_TIMESTAMP, FID_LIFETIME:         mask = 64'hFFFF_FFFF_FFFF_FFFF;
         default:                             mask = 64'h0000_0000_FFFF_FFFF;
      endcase
      return mask;
   endfunction

endpackage

// ===== hw/rtl/bundle_primary_block_parser_unit.sv =====
// Primary block parser: takes the header one byte per transaction and emits each finished
// field. Every byte is decoded in the cycle it is accepted, so a new byte can be taken in
// every clock cycle; the only limit is the single output register, which holds a result
// until the consumer takes it. A version or dictionary byte yields one result, an SDNV
// continuation byte yields none, and the closing byte of an SDNV yields the field value
// masked to its width, with an overflow flag if the value needed more than 64 bits. A
// byte with restart set starts a new header and is taken as the version byte.
module bundle_primary_block_parser_unit
   import bpbp_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [7:0]              req_data_byte,
   input  logic                    req_restart,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [FieldIdWidth-1:0] rsp_field_id,
   output logic [ValueWidth-1:0]   rsp_field_value,
   output logic                    rsp_header_done,
   output logic                    rsp_overflow
);

   field_id_type   field_index_ff, field_index_in;
   value_type      acc_ff, acc_in;
   logic           ovf_ff, ovf_in;
   dict_count_type dict_ff, dict_in;

   logic           rsp_valid_ff, rsp_valid_in;
   field_id_type   rsp_id_ff;
   value_type      rsp_value_ff;
   logic           rsp_done_ff;
   logic           rsp_ovf_ff;

   logic           take;
   field_id_type   cur_id;
   value_type      cur_acc;
   logic           cur_ovf;
   dict_count_type cur_dict;
   dict_count_type dict_dec;
   value_type      shifted;
   value_type      masked;
   logic           shift_ovf;

   logic           emit;
   field_id_type   emit_id;
   value_type      emit_value;
   logic           emit_done;
   logic           emit_ovf;

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign take      = req_valid & ~req_stall;

   always_comb begin
      if (req_restart || field_index_ff > FID_ADU) begin
         cur_id = FID_VERSION;
      end else begin
         cur_id = field_index_ff;
      end
      cur_acc  = req_restart ? '0 : acc_ff;
      cur_ovf  = req_restart ? 1'b0 : ovf_ff;
      cur_dict = req_restart ? '0 : dict_ff;
   end

   assign dict_dec  = cur_dict - dict_count_type'(1);
   assign shift_ovf = cur_ovf | (cur_acc[ValueWidth-1 -: 7] != 7'd0);
   assign shifted   = {cur_acc[ValueWidth-8:0], req_data_byte[6:0]};
   assign masked    = shifted & width_mask(cur_id);

   always_comb begin
      field_index_in = cur_id;
      acc_in         = cur_acc;
      ovf_in         = cur_ovf;
      dict_in        = cur_dict;
      emit           = 1'b0;
      emit_id        = cur_id;
      emit_value     = '0;
      emit_done      = 1'b0;
      emit_ovf       = 1'b0;

      if (cur_id == FID_VERSION) begin
         emit           = 1'b1;
         emit_value     = {56'd0, req_data_byte};
         field_index_in = FID_FLAGS;
      end else if (cur_id == FID_DICT_BYTE) begin
         emit       = 1'b1;
         emit_value = {56'd0, req_data_byte};
         dict_in    = dict_dec;
         if (dict_dec == '0) begin
            field_index_in = FID_FRAG;
         end
      end else if (req_data_byte[7]) begin
         // continuation byte: keep shifting
         acc_in = shifted;
         ovf_in = shift_ovf;
      end else begin
         emit       = 1'b1;
         emit_value = masked;
         emit_ovf   = shift_ovf;
         acc_in     = '0;
         ovf_in     = 1'b0;
         if (cur_id == FID_ADU) begin
            emit_done      = 1'b1;
            field_index_in = FID_VERSION;
         end else if (cur_id == FID_DICT_LEN) begin
            dict_in        = masked[DictWidth-1:0];
            field_index_in = (masked[DictWidth-1:0] != '0) ? FID_DICT_BYTE : FID_FRAG;
         end else begin
            field_index_in = cur_id + field_id_type'(1);
         end
      end
   end

   always_comb begin
      if (take && emit) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff & rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         field_index_ff <= FID_VERSION;
         acc_ff         <= '0;
         ovf_ff         <= 1'b0;
         dict_ff        <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (take) begin
            field_index_ff <= field_index_in;
            acc_ff         <= acc_in;
            ovf_ff         <= ovf_in;
            dict_ff        <= dict_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take && emit) begin
         rsp_id_ff    <= emit_id;
         rsp_value_ff <= emit_value;
         rsp_done_ff  <= emit_done;
         rsp_ovf_ff   <= emit_ovf;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_field_id    = rsp_id_ff;
   assign rsp_field_value = rsp_value_ff;
   assign rsp_header_done = rsp_done_ff;
   assign rsp_overflow    = rsp_ovf_ff;

endmodule
